>>> src/cfrr_pkg.sv
// Shared types, constants and the CRC-16 byte update for the frame receiver.
package cfrr_pkg;

  localparam int SLOT_BYTES_DEF = 64;
  localparam int SLOT_COUNT_DEF = 8;
  localparam int LEN_W          = 7;

  localparam logic [7:0]  START_BYTE_RST = 8'h5A;
  localparam logic [7:0]  ZERO_BYTE      = 8'h00;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  // result event codes
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_STORED   = 3'd1,
    EV_CRC_BAD  = 3'd2,
    EV_TOO_LONG = 3'd3,
    EV_FULL     = 3'd4,
    EV_EMPTY    = 3'd5,
    EV_BYTE     = 3'd6
  } event_t;

  // frame parser phases
  typedef enum logic [2:0] {
    PH_SOF,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_DATA,
    PH_CRC_HI,
    PH_CRC_LO
  } phase_t;

  // pop sequencer states
  typedef enum logic [1:0] {
    RD_IDLE,
    RD_LEN,
    RD_RUN
  } rd_state_t;

  // result issued into the output buffer; from_mem picks the store read data
  typedef struct packed {
    event_t           ev;
    logic [LEN_W-1:0] len;
    logic             last;
    logic             from_mem;
  } res_t;

  // result as held in the output buffer
  typedef struct packed {
    event_t           ev;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
    logic             last;
  } item_t;

  // good frame commit into the ring
  typedef struct packed {
    logic             en;
    logic [LEN_W-1:0] len;
  } commit_t;

  // CRC-16/Modbus update by one byte, reflected, LSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> src/cfrr_ifs.sv
// Valid/ready channel interfaces for the input items and the result items.
interface cfrr_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;
  logic [6:0] max_len;

  modport source (output valid, output cmd, output rx_byte, output max_len, input ready);
  modport sink   (input valid, input cmd, input rx_byte, input max_len, output ready);
endinterface

interface cfrr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] out_byte;
  logic [6:0] msg_len;
  logic       last;

  modport source (output valid, output event_res, output out_byte, output msg_len,
                  output last, input ready);
  modport sink   (input valid, input event_res, input out_byte, input msg_len,
                  input last, output ready);
endinterface

>>> src/crc_frame_receiver_with_ring_core.sv
// Serial byte: one result per accepted byte, via the pending stage and the output register;
// one byte per cycle sustained while the output side keeps up. Pop: slot length read then
// store read, one byte per cycle while output keeps up; input held off until the pop ends.
// Output side stalls are absorbed by a one-entry skid ahead of the output register.
// Reset (rst_n, synchronous): parser, ring pointers, start byte (0x5A) and the result
// pipeline clear; message store and slot lengths are not cleared and need no sweep.
module crc_frame_receiver_with_ring_core #(
  parameter int SLOT_BYTES = cfrr_pkg::SLOT_BYTES_DEF,
  parameter int SLOT_COUNT = cfrr_pkg::SLOT_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cfrr_in_if.sink    in_ch,
  cfrr_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import cfrr_pkg::*;

  localparam int IDX_W  = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int DEPTH  = SLOT_COUNT * SLOT_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [7:0]        start_byte_r;
  logic              byte_en;
  event_t            parse_ev;
  logic              st_we;
  logic [IDX_W-1:0]  parse_idx;
  commit_t           commit;
  logic              ring_full;
  logic [SLOT_W-1:0] wr_slot;
  logic [ADDR_W-1:0] st_waddr;
  logic              len_re;
  logic [SLOT_W-1:0] len_raddr;
  logic [LEN_W-1:0]  len_rdata;
  logic              st_re;
  logic [ADDR_W-1:0] st_raddr;
  logic [7:0]        st_rdata;
  logic              issue;
  res_t              issue_res;
  logic              credit_ok;

  // start byte register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= START_BYTE_RST;
    end else if (cfg_we) begin
      start_byte_r <= cfg_wdata;
    end
  end

  cfrr_parser #(.SLOT_BYTES(SLOT_BYTES)) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_en    (byte_en),
    .rx_byte    (in_ch.rx_byte),
    .start_byte (start_byte_r),
    .ring_full  (ring_full),
    .ev         (parse_ev),
    .st_we      (st_we),
    .st_idx     (parse_idx),
    .commit     (commit)
  );

  cfrr_ctrl #(.SLOT_BYTES(SLOT_BYTES), .SLOT_COUNT(SLOT_COUNT)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_cmd     (in_ch.cmd),
    .in_max_len (in_ch.max_len),
    .in_ready   (in_ch.ready),
    .byte_en    (byte_en),
    .parse_ev   (parse_ev),
    .commit     (commit),
    .parse_idx  (parse_idx),
    .ring_full  (ring_full),
    .wr_slot    (wr_slot),
    .st_waddr   (st_waddr),
    .len_re     (len_re),
    .len_raddr  (len_raddr),
    .len_rdata  (len_rdata),
    .st_re      (st_re),
    .st_raddr   (st_raddr),
    .issue      (issue),
    .issue_res  (issue_res),
    .credit_ok  (credit_ok)
  );

  // message bytes, one slot of SLOT_BYTES per ring entry
  cfrr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (in_ch.rx_byte),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // stored length per slot
  cfrr_ram #(.WIDTH(LEN_W), .DEPTH(SLOT_COUNT)) u_lens (
    .clk   (clk),
    .we    (commit.en),
    .waddr (wr_slot),
    .wdata (commit.len),
    .re    (len_re),
    .raddr (len_raddr),
    .rdata (len_rdata)
  );

  cfrr_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (issue),
    .issue_res (issue_res),
    .mem_rdata (st_rdata),
    .credit_ok (credit_ok),
    .out_ch    (out_ch)
  );

endmodule

>>> src/cfrr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cfrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/cfrr_parser.sv
// Frame parser: start byte, length, payload and CRC check on serial bytes.
module cfrr_parser #(
  parameter int SLOT_BYTES = cfrr_pkg::SLOT_BYTES_DEF,
  localparam int IDX_W = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_en,
  input  logic [7:0]       rx_byte,
  input  logic [7:0]       start_byte,
  input  logic             ring_full,
  output cfrr_pkg::event_t ev,
  output logic             st_we,
  output logic [IDX_W-1:0] st_idx,
  output cfrr_pkg::commit_t commit
);
  import cfrr_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic             hi_nz_r, hi_nz_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0] cnt_inc;
  logic [15:0]      crc_upd;

  assign crc_upd = crc16_byte(crc_r, rx_byte);
  assign cnt_inc = cnt_r + LEN_W'(1);
  assign st_idx  = cnt_r[IDX_W-1:0];

  // parse one serial byte
  always_comb begin
    phase_nxt  = phase_r;
    crc_nxt    = crc_r;
    hi_nz_nxt  = hi_nz_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    ev         = EV_NONE;
    st_we      = 1'b0;
    commit     = '0;
    if (byte_en) begin
      unique case (phase_r)
        PH_SOF: begin
          if (rx_byte == start_byte) begin
            phase_nxt = PH_LEN_HI;
            crc_nxt   = CRC_INIT;
          end
        end
        PH_LEN_HI: begin
          hi_nz_nxt = |rx_byte;
          crc_nxt   = crc_upd;
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          crc_nxt = crc_upd;
          cnt_nxt = '0;
          len_nxt = rx_byte[LEN_W-1:0];
          if (hi_nz_r || (int'(rx_byte) > SLOT_BYTES)) begin
            phase_nxt = PH_SOF;
            ev        = EV_TOO_LONG;
          end else if (rx_byte == ZERO_BYTE) begin
            phase_nxt = PH_CRC_HI;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          crc_nxt = crc_upd;
          st_we   = 1'b1;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= len_r) begin
            phase_nxt = PH_CRC_HI;
          end
        end
        PH_CRC_HI: begin
          if (rx_byte == crc_r[15:8]) begin
            phase_nxt = PH_CRC_LO;
          end else begin
            phase_nxt = PH_SOF;
            ev        = EV_CRC_BAD;
          end
        end
        PH_CRC_LO: begin
          phase_nxt = PH_SOF;
          if (rx_byte == crc_r[7:0]) begin
            if (ring_full) begin
              ev = EV_FULL;
            end else begin
              ev         = EV_STORED;
              commit.en  = 1'b1;
              commit.len = len_r;
            end
          end else begin
            ev = EV_CRC_BAD;
          end
        end
        default: phase_nxt = PH_SOF;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SOF;
      crc_r   <= CRC_INIT;
      hi_nz_r <= 1'b0;
      len_r   <= '0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      crc_r   <= crc_nxt;
      hi_nz_r <= hi_nz_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> src/cfrr_ctrl.sv
// Ring pointers, input acceptance and the pop sequencer that streams a slot.
module cfrr_ctrl #(
  parameter int SLOT_BYTES = cfrr_pkg::SLOT_BYTES_DEF,
  parameter int SLOT_COUNT = cfrr_pkg::SLOT_COUNT_DEF,
  localparam int IDX_W  = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1,
  localparam int SLOT_W = $clog2(SLOT_COUNT),
  localparam int ADDR_W = $clog2(SLOT_COUNT * SLOT_BYTES)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_cmd,
  input  logic [cfrr_pkg::LEN_W-1:0] in_max_len,
  output logic                      in_ready,
  output logic                      byte_en,
  input  cfrr_pkg::event_t          parse_ev,
  input  cfrr_pkg::commit_t         commit,
  input  logic [IDX_W-1:0]          parse_idx,
  output logic                      ring_full,
  output logic [SLOT_W-1:0]         wr_slot,
  output logic [ADDR_W-1:0]         st_waddr,
  output logic                      len_re,
  output logic [SLOT_W-1:0]         len_raddr,
  input  logic [cfrr_pkg::LEN_W-1:0] len_rdata,
  output logic                      st_re,
  output logic [ADDR_W-1:0]         st_raddr,
  output logic                      issue,
  output cfrr_pkg::res_t            issue_res,
  input  logic                      credit_ok
);
  import cfrr_pkg::*;

  rd_state_t        state_r, state_nxt;
  logic [SLOT_W-1:0] wr_slot_r, wr_slot_nxt;
  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt;
  logic [LEN_W-1:0] maxl_r, maxl_nxt;
  logic [LEN_W-1:0] n_r, n_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic [LEN_W-1:0] idx_inc;
  logic [LEN_W-1:0] n_cap;
  logic             in_fire;
  logic             empty;
  logic             run_done;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(SLOT_COUNT - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  assign empty     = (rd_slot_r == wr_slot_r);
  assign ring_full = (next_slot(wr_slot_r) == rd_slot_r);
  assign wr_slot   = wr_slot_r;
  assign len_raddr = rd_slot_r;
  assign in_ready  = (state_r == RD_IDLE) && credit_ok;
  assign in_fire   = in_valid && in_ready;
  assign idx_inc   = idx_r + LEN_W'(1);
  assign run_done  = credit_ok && ((n_r == '0) || (idx_inc == n_r));

  // slot base plus byte offset into the message store
  assign st_waddr = ADDR_W'(wr_slot_r) * ADDR_W'(SLOT_BYTES) + ADDR_W'(parse_idx);
  assign st_raddr = ADDR_W'(rd_slot_r) * ADDR_W'(SLOT_BYTES) + ADDR_W'(idx_r[IDX_W-1:0]);

  // delivered length: stored length cut to slot size and reader limit
  always_comb begin
    n_cap = (int'(len_rdata) > SLOT_BYTES) ? LEN_W'(SLOT_BYTES) : len_rdata;
    if (n_cap > maxl_r) begin
      n_cap = maxl_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      RD_IDLE: if (in_fire && in_cmd && !empty) state_nxt = RD_LEN;
      RD_LEN:  state_nxt = RD_RUN;
      RD_RUN:  if (run_done) state_nxt = RD_IDLE;
      default: state_nxt = RD_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    byte_en   = 1'b0;
    len_re    = 1'b0;
    st_re     = 1'b0;
    issue     = 1'b0;
    issue_res = '{ev: EV_NONE, len: '0, last: 1'b1, from_mem: 1'b0};
    unique case (state_r)
      RD_IDLE: begin
        byte_en = in_fire && !in_cmd;
        len_re  = in_fire && in_cmd && !empty;
        issue   = in_fire && (!in_cmd || empty);
        issue_res.ev = in_cmd ? EV_EMPTY : parse_ev;
      end
      RD_LEN: begin
      end
      RD_RUN: begin
        issue        = credit_ok;
        issue_res.ev = EV_BYTE;
        if (n_r != '0) begin
          st_re              = credit_ok;
          issue_res.len      = n_r;
          issue_res.last     = (idx_inc == n_r);
          issue_res.from_mem = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // pointers and pop counters
  always_comb begin
    wr_slot_nxt = wr_slot_r;
    rd_slot_nxt = rd_slot_r;
    maxl_nxt    = maxl_r;
    n_nxt       = n_r;
    idx_nxt     = idx_r;
    if (commit.en) begin
      wr_slot_nxt = next_slot(wr_slot_r);
    end
    if (in_fire) begin
      maxl_nxt = in_max_len;
    end
    if (state_r == RD_LEN) begin
      n_nxt   = n_cap;
      idx_nxt = '0;
    end
    if ((state_r == RD_RUN) && credit_ok) begin
      idx_nxt = idx_inc;
      if (run_done) begin
        rd_slot_nxt = next_slot(rd_slot_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= RD_IDLE;
      wr_slot_r <= '0;
      rd_slot_r <= '0;
      maxl_r    <= '0;
      n_r       <= '0;
      idx_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      wr_slot_r <= wr_slot_nxt;
      rd_slot_r <= rd_slot_nxt;
      maxl_r    <= maxl_nxt;
      n_r       <= n_nxt;
      idx_r     <= idx_nxt;
    end
  end

endmodule

>>> src/cfrr_outbuf.sv
// Result pipeline: read-data stage, skid entry and output register.
module cfrr_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                issue,
  input  cfrr_pkg::res_t      issue_res,
  input  logic [7:0]          mem_rdata,
  output logic                credit_ok,
  cfrr_out_if.source          out_ch
);
  import cfrr_pkg::*;

  logic  pend_v_r, pend_v_nxt;
  res_t  pend_r, pend_nxt;
  logic  hold_v_r, hold_v_nxt;
  item_t hold_r, hold_nxt;
  logic  out_v_r, out_v_nxt;
  item_t out_r, out_nxt;
  item_t arrive;
  logic  fire;
  logic [1:0] occ;

  // store read data lines up with the result issued in the previous cycle
  always_comb begin
    arrive.ev   = pend_r.ev;
    arrive.data = pend_r.from_mem ? mem_rdata : ZERO_BYTE;
    arrive.len  = pend_r.len;
    arrive.last = pend_r.last;
  end

  assign fire      = out_v_r && out_ch.ready;
  assign occ       = 2'(out_v_r) + 2'(hold_v_r) + 2'(pend_v_r);
  assign credit_ok = (occ - 2'(fire)) < 2'd2;

  // move results forward, oldest first
  always_comb begin
    pend_v_nxt = issue;
    pend_nxt   = issue_res;
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    if (!out_v_r || fire) begin
      if (hold_v_r) begin
        out_v_nxt  = 1'b1;
        out_nxt    = hold_r;
        hold_v_nxt = pend_v_r;
        hold_nxt   = arrive;
      end else if (pend_v_r) begin
        out_v_nxt = 1'b1;
        out_nxt   = arrive;
      end else begin
        out_v_nxt = 1'b0;
      end
    end else if (pend_v_r) begin
      hold_v_nxt = 1'b1;
      hold_nxt   = arrive;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.event_res = out_r.ev;
  assign out_ch.out_byte  = out_r.data;
  assign out_ch.msg_len   = out_r.len;
  assign out_ch.last      = out_r.last;

endmodule

>>> test/testbench.sv
// Self-checking testbench for the serial frame receiver with its ring of message slots.
module testbench;
  import cfrr_pkg::*;

  localparam int SLOT_SIZE   = SLOT_BYTES_DEF;
  localparam int STORE_SLOTS = SLOT_COUNT_DEF;
  localparam int IDLE_PCT    = 30;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // one host-side input item
  typedef struct packed {
    logic       cmd;
    logic [7:0] rx;
    logic [6:0] maxl;
  } host_item_t;

  typedef enum logic [1:0] {
    FR_GOOD,
    FR_BAD_HI,
    FR_BAD_LO,
    FR_TOO_LONG
  } frame_kind_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  cfrr_in_if  in_ch ();
  cfrr_out_if out_ch ();

  crc_frame_receiver_with_ring_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  host_item_t pending_items[$];
  item_t      expected_results[$];
  int         items_queued = 0;
  int         mismatches = 0;
  int unsigned cycle_no = 0;
  bit         calm = 1'b0;
  bit         stall_go = 1'b0;
  int         hold_left;

  // predictor state: parser, ring and the start byte setting
  logic [7:0]  start_val = START_BYTE_RST;
  phase_t      parse_ph = PH_SOF;
  logic [15:0] crc_acc = CRC_INIT;
  logic [15:0] frame_len = '0;
  logic [6:0]  data_cnt = '0;
  logic [7:0]  msg_mem [0:STORE_SLOTS*SLOT_SIZE-1];
  logic [6:0]  slot_len [0:STORE_SLOTS-1];
  int          wr_slot = 0;
  int          rd_slot = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // CRC-16 with the reflected polynomial, one data bit at a time, LSB first
  function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c;
    for (int k = 0; k < 8; k++) begin
      if (r[0] ^ b[k]) r = (r >> 1) ^ CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  function automatic int ring_next(input int s);
    return (s + 1 >= STORE_SLOTS) ? 0 : s + 1;
  endfunction

  function automatic item_t result_of(input event_t ev, input logic [7:0] d,
                                      input logic [6:0] n, input logic l);
    item_t r;
    r.ev   = ev;
    r.data = d;
    r.len  = n;
    r.last = l;
    return r;
  endfunction

  // advance the predictor by one accepted item and queue what it should produce
  task automatic record_item(input logic cmd, input logic [7:0] b, input logic [6:0] ml);
    event_t ev;
    int n;
    int base;
    ev = EV_NONE;
    if (!cmd) begin
      case (parse_ph)
        PH_SOF: begin
          if (b == start_val) begin
            parse_ph = PH_LEN_HI;
            crc_acc = CRC_INIT;
          end
        end
        PH_LEN_HI: begin
          frame_len = {b, 8'h00};
          crc_acc = crc_next(crc_acc, b);
          parse_ph = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          frame_len[7:0] = b;
          crc_acc = crc_next(crc_acc, b);
          data_cnt = '0;
          if (frame_len > SLOT_SIZE) begin
            parse_ph = PH_SOF;
            ev = EV_TOO_LONG;
          end else if (frame_len == 0) begin
            parse_ph = PH_CRC_HI;
          end else begin
            parse_ph = PH_DATA;
          end
        end
        PH_DATA: begin
          crc_acc = crc_next(crc_acc, b);
          if (data_cnt < SLOT_SIZE) msg_mem[wr_slot*SLOT_SIZE + data_cnt] = b;
          data_cnt = data_cnt + 7'd1;
          if (data_cnt >= frame_len) parse_ph = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          if (b == crc_acc[15:8]) begin
            parse_ph = PH_CRC_LO;
          end else begin
            parse_ph = PH_SOF;
            ev = EV_CRC_BAD;
          end
        end
        PH_CRC_LO: begin
          if (b == crc_acc[7:0]) begin
            // one slot always stays free, so next == read means full
            if (ring_next(wr_slot) == rd_slot) begin
              ev = EV_FULL;
            end else begin
              slot_len[wr_slot] = frame_len[6:0];
              wr_slot = ring_next(wr_slot);
              ev = EV_STORED;
            end
          end else begin
            ev = EV_CRC_BAD;
          end
          parse_ph = PH_SOF;
        end
        default: parse_ph = PH_SOF;
      endcase
      expected_results.push_back(result_of(ev, ZERO_BYTE, '0, 1'b1));
    end else if (rd_slot == wr_slot) begin
      expected_results.push_back(result_of(EV_EMPTY, ZERO_BYTE, '0, 1'b1));
    end else begin
      n = slot_len[rd_slot];
      if (n > ml) n = ml;
      base = rd_slot * SLOT_SIZE;
      rd_slot = ring_next(rd_slot);
      if (n == 0) begin
        expected_results.push_back(result_of(EV_BYTE, ZERO_BYTE, '0, 1'b1));
      end else begin
        for (int i = 0; i < n; i++) begin
          expected_results.push_back(result_of(EV_BYTE, msg_mem[base + i], 7'(n),
                                               i == n - 1));
        end
      end
    end
  endtask

  task automatic note_mismatch(input string msg);
    $display("MISMATCH cycle %0d: %s", cycle_no, msg);
    mismatches++;
  endtask

  // stimulus builders
  task automatic queue_byte(input logic [7:0] b);
    host_item_t it;
    it.cmd  = 1'b0;
    it.rx   = b;
    it.maxl = 7'($urandom_range(0, SLOT_SIZE));
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_pop(input logic [6:0] ml);
    host_item_t it;
    it.cmd  = 1'b1;
    it.rx   = 8'($urandom_range(0, 255));
    it.maxl = ml;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // a whole frame with random payload; pop_after >= 0 slips a pop in after that byte
  task automatic queue_frame(input logic [15:0] flen, input frame_kind_t kind,
                             input int pop_after);
    logic [15:0] crc;
    logic [7:0]  d;
    crc = CRC_INIT;
    queue_byte(start_val);
    queue_byte(flen[15:8]);
    crc = crc_next(crc, flen[15:8]);
    queue_byte(flen[7:0]);
    crc = crc_next(crc, flen[7:0]);
    if (kind == FR_TOO_LONG) return;
    for (int i = 0; i < flen; i++) begin
      d = 8'($urandom_range(0, 255));
      queue_byte(d);
      crc = crc_next(crc, d);
      if (i == pop_after) queue_pop(7'(SLOT_SIZE));
    end
    d = 8'($urandom_range(1, 255));
    if (kind == FR_BAD_HI) begin
      queue_byte(crc[15:8] ^ d);
      return;
    end
    queue_byte(crc[15:8]);
    queue_byte(kind == FR_BAD_LO ? (crc[7:0] ^ d) : crc[7:0]);
  endtask

  // mostly well-formed frames, some broken ones, noise and pops
  task automatic run_random(input int count);
    int first;
    int r;
    int len;
    int pick;
    logic [15:0] flen;
    first = items_queued;
    while (items_queued - first < count) begin
      r = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      len = (pick < 75) ? $urandom_range(0, 6) :
            (pick < 95) ? $urandom_range(7, SLOT_SIZE - 1) : SLOT_SIZE;
      if (r < 55) begin
        queue_frame(16'(len), FR_GOOD,
                    (len > 0 && $urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1);
      end else if (r < 62) begin
        queue_frame(16'(len), FR_BAD_HI, -1);
      end else if (r < 68) begin
        queue_frame(16'(len), FR_BAD_LO, -1);
      end else if (r < 73) begin
        if ($urandom_range(0, 1)) flen = {8'h00, 8'($urandom_range(SLOT_SIZE + 1, 255))};
        else flen = {8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))};
        queue_frame(flen, FR_TOO_LONG, -1);
      end else if (r < 80) begin
        repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)));
      end else begin
        pick = $urandom_range(0, 99);
        queue_pop(7'((pick < 40) ? SLOT_SIZE :
                     (pick < 60) ? $urandom_range(0, 3) : $urandom_range(0, SLOT_SIZE)));
      end
    end
  endtask

  // block is idle once everything is sent and every result is back
  task automatic wait_drained;
    while (pending_items.size() != 0 || expected_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic set_start_byte(input logic [7:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    start_val = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // input driver: holds an offered item until its transfer
  always @(posedge clk) begin : drive_proc
    logic took;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      took = in_ch.valid && in_ch.ready;
      if (took) begin
        record_item(in_ch.cmd, in_ch.rx_byte, in_ch.max_len);
        void'(pending_items.pop_front());
      end
      if (!(in_ch.valid && !took)) begin
        if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_ch.valid   <= 1'b1;
          in_ch.cmd     <= pending_items[0].cmd;
          in_ch.rx_byte <= pending_items[0].rx;
          in_ch.max_len <= pending_items[0].maxl;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) hold_left <= 0;
    else if (stall_go) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // result monitor: each transfer against the oldest expectation
  always @(posedge clk) begin : watch_proc
    item_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result, event %0d", out_ch.event_res));
        end else begin
          want = expected_results.pop_front();
          if (out_ch.event_res !== want.ev)
            note_mismatch($sformatf("event got %0d expected %0d", out_ch.event_res, want.ev));
          if (out_ch.out_byte !== want.data)
            note_mismatch($sformatf("byte got %h expected %h", out_ch.out_byte, want.data));
          if (out_ch.msg_len !== want.len)
            note_mismatch($sformatf("length got %0d expected %0d", out_ch.msg_len, want.len));
          if (out_ch.last !== want.last)
            note_mismatch($sformatf("last got %b expected %b", out_ch.last, want.last));
        end
      end
      out_ch.ready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < STORE_SLOTS*SLOT_SIZE; i++) msg_mem[i] = ZERO_BYTE;
    for (int i = 0; i < STORE_SLOTS; i++) slot_len[i] = '0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = ZERO_BYTE;
    in_ch.valid   = 1'b0;
    in_ch.cmd     = 1'b0;
    in_ch.rx_byte = ZERO_BYTE;
    in_ch.max_len = '0;
    out_ch.ready  = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: noise, empty pops, zero length, oversize, pop mid-frame, truncation, bad CRC
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_pop(7'(SLOT_SIZE));
    queue_frame(16'h0000, FR_GOOD, -1);
    queue_frame(16'hFFFF, FR_TOO_LONG, -1);
    queue_frame(16'h0002, FR_GOOD, 0);
    queue_pop(7'd1);
    queue_frame(16'h0000, FR_BAD_LO, -1);
    queue_pop(7'd0);
    wait_drained();

    set_start_byte(8'h00);
    run_random(6);
    wait_drained();

    // no idling on either side for this stretch
    calm = 1'b1;
    set_start_byte(8'hFF);
    run_random(6);
    wait_drained();
    calm = 1'b0;

    // receiver holds off while the sender keeps offering
    set_start_byte(8'($urandom_range(1, 254)));
    run_random(6);
    stall_go = 1'b1;
    @(negedge clk);
    stall_go = 1'b0;
    wait_drained();

    set_start_byte(START_BYTE_RST);
    run_random(6);
    wait_drained();

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
